@@ rtl/dns_query_to_answer_rewriter_defines.svh @@
// Assertion helpers shared by the rewriter modules.
`ifndef DNS_QUERY_TO_ANSWER_REWRITER_DEFINES_SVH
`define DNS_QUERY_TO_ANSWER_REWRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dqar_pkg.sv @@
`default_nettype none
package dqar_pkg;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_LENGTH    = 3'd1,
    PH_LABEL     = 3'd2,
    PH_POINTER   = 3'd3,
    PH_TYPECLASS = 3'd4,
    PH_DROP      = 3'd5
  } phase_t;

  typedef enum logic {
    KIND_PASS   = 1'b0,
    KIND_ANSWER = 1'b1
  } kind_t;

  // One queued job for the back end.
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data;   // byte to send first (last QCLASS byte for an answer)
    logic         last;
    logic         err;
    logic [23:0]  tc_hi;  // first three QTYPE/QCLASS bytes, oldest on top
  } job_t;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [3:0] HDR_FLAGS_OFS = 4'd2;
  localparam logic [3:0] HDR_ANC_HI    = 4'd6;
  localparam logic [3:0] HDR_ANC_LO    = 4'd7;
  localparam logic [3:0] HDR_LAST_OFS  = 4'd11;

  localparam logic [7:0] PTR_MIN       = 8'd192;
  localparam logic [7:0] QR_BIT        = 8'h80;
  localparam logic [7:0] ANC_HI_BYTE   = 8'h00;
  localparam logic [7:0] ANC_LO_BYTE   = 8'h01;

  localparam logic [7:0] ANS_PTR_HI    = 8'hC0;
  localparam logic [7:0] ANS_PTR_LO    = 8'h0C;
  localparam logic [7:0] ANS_RDLEN_HI  = 8'h00;
  localparam logic [7:0] ANS_RDLEN_LO  = 8'h04;
  localparam logic [4:0] ANS_LAST_SEQ  = 5'd16;

  localparam logic [31:0] TTL_RST      = 32'd2;
  localparam logic [31:0] ADDR_RST     = 32'd757935405;

  typedef enum logic {
    CFG_TTL  = 1'b0,
    CFG_ADDR = 1'b1
  } cfg_idx_t;

endpackage
`default_nettype wire

@@ rtl/dqar_front.sv @@
`default_nettype none
module dqar_front import dqar_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] qbyte,
  input  wire logic       qlast,
  output job_t            job,
  output logic            push
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_ofs_r, hdr_ofs_nxt;
  logic [7:0]  label_rem_r, label_rem_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [23:0] tc_r, tc_nxt;

  logic        pass;
  logic        answer;
  logic [7:0]  ob;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_ofs_nxt   = hdr_ofs_r;
    label_rem_nxt = label_rem_r;
    tail_nxt      = tail_r;
    tc_nxt        = tc_r;
    pass          = 1'b1;
    answer        = 1'b0;
    ob            = qbyte;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_ofs_r == HDR_FLAGS_OFS) begin
          ob = qbyte | QR_BIT;
        end else if (hdr_ofs_r == HDR_ANC_HI) begin
          ob = ANC_HI_BYTE;
        end else if (hdr_ofs_r == HDR_ANC_LO) begin
          ob = ANC_LO_BYTE;
        end
        if (hdr_ofs_r >= HDR_LAST_OFS) begin
          hdr_ofs_nxt = '0;
          phase_nxt   = PH_LENGTH;
        end else begin
          hdr_ofs_nxt = hdr_ofs_r + 4'd1;
        end
      end
      PH_LENGTH: begin
        if (qbyte == 8'd0) begin
          tail_nxt  = '0;
          phase_nxt = PH_TYPECLASS;
        end else if (qbyte >= PTR_MIN) begin
          phase_nxt = PH_POINTER;
        end else begin
          label_rem_nxt = qbyte;
          phase_nxt     = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_rem_nxt = label_rem_r - 8'd1;
        if (label_rem_r == 8'd1) begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_POINTER: begin
        tail_nxt  = '0;
        phase_nxt = PH_TYPECLASS;
      end
      PH_TYPECLASS: begin
        tc_nxt   = {tc_r[15:0], qbyte};
        tail_nxt = tail_r + 2'd1;
        if (tail_r == 2'd3) begin
          pass      = 1'b0;
          answer    = 1'b1;
          phase_nxt = PH_DROP;
        end
      end
      PH_DROP: begin
        pass = 1'b0;
      end
      default: begin
        // undefined phase code: restart as header byte zero
        hdr_ofs_nxt = 4'd1;
        phase_nxt   = PH_HEADER;
      end
    endcase
    // end of packet: return everything to the start-of-packet state
    if (qlast) begin
      phase_nxt     = PH_HEADER;
      hdr_ofs_nxt   = '0;
      label_rem_nxt = '0;
      tail_nxt      = '0;
      tc_nxt        = '0;
    end
  end

  always_comb begin
    push      = acc && (pass || answer);
    job.kind  = answer ? KIND_ANSWER : KIND_PASS;
    job.data  = ob;
    job.last  = pass && qlast;
    job.err   = pass && qlast;
    job.tc_hi = tc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_ofs_r   <= '0;
      label_rem_r <= '0;
      tail_r      <= '0;
      tc_r        <= '0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      hdr_ofs_r   <= hdr_ofs_nxt;
      label_rem_r <= label_rem_nxt;
      tail_r      <= tail_nxt;
      tc_r        <= tc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dqar_fifo.sv @@
`default_nettype none
`include "dns_query_to_answer_rewriter_defines.svh"
module dqar_fifo import dqar_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `DQAR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH), "queue count over depth")
  `DQAR_ASSERT_NOW(a_no_overflow, full, !push, "push into full queue")
  `DQAR_ASSERT_NOW(a_no_underflow, empty, !pop, "pop from empty queue")
  `DQAR_ASSERT_NOW(a_ptr_gap, !full, cnt_r[QPTR_W-1:0] == QPTR_W'(wr_ptr_r - rd_ptr_r),
    "queue pointers disagree with count")

endmodule
`default_nettype wire

@@ rtl/dqar_back.sv @@
`default_nettype none
`include "dns_query_to_answer_rewriter_defines.svh"
module dqar_back import dqar_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire job_t        head,
  input  wire logic        empty,
  output logic             pop,
  input  wire logic [31:0] ttl,
  input  wire logic [31:0] addr,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  logic [4:0]  seq_r, seq_nxt;
  logic        vld_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic        err_r;

  logic        load;
  logic [7:0]  byte_sel;
  logic        last_sel;
  logic        job_done;

  assign load = !empty && (!vld_r || out_tready);

  always_comb begin
    byte_sel = head.data;
    last_sel = head.last;
    if (head.kind == KIND_ANSWER) begin
      last_sel = (seq_r == ANS_LAST_SEQ);
      case (seq_r)
        5'd0:    byte_sel = head.data;
        5'd1:    byte_sel = ANS_PTR_HI;
        5'd2:    byte_sel = ANS_PTR_LO;
        5'd3:    byte_sel = head.tc_hi[23:16];
        5'd4:    byte_sel = head.tc_hi[15:8];
        5'd5:    byte_sel = head.tc_hi[7:0];
        5'd6:    byte_sel = head.data;
        5'd7:    byte_sel = ttl[31:24];
        5'd8:    byte_sel = ttl[23:16];
        5'd9:    byte_sel = ttl[15:8];
        5'd10:   byte_sel = ttl[7:0];
        5'd11:   byte_sel = ANS_RDLEN_HI;
        5'd12:   byte_sel = ANS_RDLEN_LO;
        5'd13:   byte_sel = addr[31:24];
        5'd14:   byte_sel = addr[23:16];
        5'd15:   byte_sel = addr[15:8];
        5'd16:   byte_sel = addr[7:0];
        default: byte_sel = head.data;
      endcase
    end
    job_done = (head.kind == KIND_PASS) || (seq_r == ANS_LAST_SEQ);
    pop      = load && job_done;
    seq_nxt  = seq_r;
    if (load) begin
      seq_nxt = job_done ? 5'd0 : seq_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= byte_sel;
      last_r <= last_sel;
      err_r  <= (head.kind == KIND_PASS) && head.err;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

  `DQAR_ASSERT_NOW(a_seq_in_answer, seq_r != 5'd0, !empty && head.kind == KIND_ANSWER,
    "answer sequence running without an answer job")
  `DQAR_ASSERT_NOW(a_seq_bound, 1'b1, seq_r <= ANS_LAST_SEQ, "answer sequence past end")
  `DQAR_ASSERT_NEXT(a_answer_end, load && head.kind == KIND_ANSWER && seq_r == ANS_LAST_SEQ,
    out_tvalid && out_tlast && !out_tuser, "answer did not end with clean last byte")

endmodule
`default_nettype wire

@@ rtl/dns_query_to_answer_rewriter.sv @@
`default_nettype none
// Reply bytes pass the job queue, then the output register that drives out_*.
// One query byte per cycle while the job queue is not full; an answer job holds the output
// stage for its 17 bytes; the 4-entry parser-to-emitter queue sets how long input flows.
// Synchronous active-low reset returns the parser to the header, empties the queue,
// and loads TTL 2 and address 45.45.45.45.
module dns_query_to_answer_rewriter import dqar_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] query_byte
  input  wire logic        in_tlast,   // query_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] reply_byte
  output logic             out_tlast,  // reply_last
  output logic             out_tuser,  // [0] reply_error
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] ttl_r;
  logic [31:0] addr_r;

  job_t        push_job;
  job_t        head_job;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic        in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r  <= TTL_RST;
      addr_r <= ADDR_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TTL:  ttl_r  <= cfg_data;
        CFG_ADDR: addr_r <= cfg_data;
        default:  ttl_r  <= ttl_r;
      endcase
    end
  end

  dqar_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .qbyte (in_tdata),
    .qlast (in_tlast),
    .job   (push_job),
    .push  (push)
  );

  dqar_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (full),
    .empty  (empty)
  );

  dqar_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_job),
    .empty      (empty),
    .pop        (pop),
    .ttl        (ttl_r),
    .addr       (addr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
